### rtl/scp_pkg.sv
// ----------------------------------------------------------------------------
// scp_pkg: shared constants for the sine/cosine polynomial block
// fixed-point formats, reduction constants and reciprocal multipliers
// ----------------------------------------------------------------------------
package scp_pkg;

  localparam int ANGLE_W = 32;   // Q7.24 signed angle
  localparam int VALUE_W = 32;   // Q1.30 signed result
  localparam int RED_W   = 40;   // |angle| in Q.32
  localparam int FOLD_W  = 33;   // remainder below pi/2 in Q.32
  localparam int POLY_W  = 30;   // polynomial operand in Q.30

  // pipeline depth from start to result strobe
  localparam int LATENCY = 12;

  // function select codes
  localparam logic OPC_SINE   = 1'b0;
  localparam logic OPC_COSINE = 1'b1;

  localparam logic [VALUE_W-1:0] ONE_Q30 = 32'd1073741824;

  // pi/2 in Q.32, round(pi * 2^31); pi/4 is exactly half of it
  localparam logic [RED_W-1:0]  HALF_PI_Q32    = 40'd6746518852;
  localparam logic [FOLD_W-1:0] HALF_PI_F      = 33'd6746518852;
  localparam logic [FOLD_W-1:0] QUARTER_PI_Q32 = 33'd3373259426;

  // floor(x/d) = (x * ceil(2^k/d)) >> k, exact for x below 2^29
  localparam logic [28:0] RECIP3  = 29'd357913942;   // d = 3,  k = 30
  localparam logic [29:0] RECIP15 = 30'd572662307;   // d = 15, k = 33
  localparam logic [29:0] RECIP45 = 30'd763549742;   // d = 45, k = 35

endpackage

### rtl/sine_cosine_polynomial.sv
// ----------------------------------------------------------------------------
// sine_cosine_polynomial: pipelined sine/cosine by quadrant folding and
// short taylor polynomials
// throughput: one transaction per cycle, busy is low whenever out of reset
// the twelve stages are set by the 7-step quotient search against pi/2 and
// the chain of three dependent 30x30 products
// reset: synchronous, clears every valid bit; data registers are not reset
// ----------------------------------------------------------------------------
module sine_cosine_polynomial (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [scp_pkg::ANGLE_W-1:0] in_angle,
  input  logic                               in_opcode,
  output logic                               out_valid,
  output logic signed [scp_pkg::VALUE_W-1:0] out_value
);
  import scp_pkg::*;

  // one conditional subtract of a shifted pi/2, gives quotient bit and remainder
  function automatic logic [RED_W:0] div_step(input logic [RED_W-1:0] rem,
                                              input logic [RED_W-1:0] dvs);
    logic ge;
    ge = (rem >= dvs);
    return {ge, ge ? (rem - dvs) : rem};
  endfunction

  logic                 accept;
  logic [LATENCY-1:0]   vld_r;
  logic [LATENCY-1:0]   vld_nxt;

  // stage 0: magnitude in Q.32
  logic [ANGLE_W-1:0]   ang_u;
  logic [ANGLE_W-1:0]   mag_nxt;
  logic [RED_W-1:0]     s0_m_r;
  logic                 s0_neg_r, s0_cos_r;

  // stages 1..4: quotient search, only the two low quotient bits matter
  logic [RED_W:0]       st_a, st_b, st_c, st_d, st_e, st_f, st_g;
  logic [RED_W-1:0]     s1_rem_r, s2_rem_r, s3_rem_r;
  logic                 s1_neg_r, s2_neg_r, s3_neg_r, s4_neg_r;
  logic                 s1_cos_r, s2_cos_r, s3_cos_r, s4_cos_r;
  logic                 s3_q1_r, s4_q1_r, s4_q0_r;
  logic [FOLD_W-1:0]    s4_f0_r;

  // stage 5: quadrant, sign and folded operand
  logic [1:0]           q_lo;
  logic [1:0]           quad;
  logic                 lo_sel, swap, negres_nxt;
  logic [FOLD_W-1:0]    f_hi;
  logic [POLY_W-1:0]    u_nxt;
  logic [POLY_W-1:0]    s5_u_r;
  logic                 s5_pc_r, s5_neg_r;

  // stages 6..9: powers and constant divisions
  logic [2*POLY_W-1:0]  p_u2, p_a, p_b;
  logic [POLY_W-1:0]    mul_b;
  logic [POLY_W-1:0]    s6_u_r, s6_u2_r;
  logic                 s6_pc_r, s6_neg_r;
  logic [POLY_W-1:0]    s7_u_r, s7_u2_r, s7_a_r;
  logic                 s7_pc_r, s7_neg_r;
  logic [28:0]          da_x;
  logic [57:0]          p_da;
  logic [POLY_W-1:0]    s8_u_r, s8_u2_r, s8_b_r;
  logic [27:0]          s8_da_r;
  logic                 s8_pc_r, s8_neg_r;
  logic [26:0]          db_x;
  logic [29:0]          db_m;
  logic [56:0]          p_db;
  logic [23:0]          db_nxt;
  logic [POLY_W-1:0]    s9_u_r, s9_u2_r;
  logic [27:0]          s9_da_r;
  logic [23:0]          s9_db_r;
  logic                 s9_pc_r, s9_neg_r;

  // stages 10..11: sum, clamp, sign
  logic [VALUE_W-1:0]   sum_nxt;
  logic [VALUE_W-1:0]   s10_sum_r;
  logic                 s10_neg_r;
  logic [VALUE_W-1:0]   sat;
  logic [VALUE_W-1:0]   out_value_nxt;
  logic [VALUE_W-1:0]   out_value_r;

  // no backpressure anywhere: out of reset the pipeline takes a transaction every cycle
  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  // valid bits ride alongside the data
  assign vld_nxt = {vld_r[LATENCY-2:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // ---- stage 0: take |angle|, shift into Q.32 (the most negative angle
  // gives 2^31, which still fits unsigned)
  assign ang_u   = in_angle;
  assign mag_nxt = ang_u[ANGLE_W-1] ? (~ang_u + 32'd1) : ang_u;

  always_ff @(posedge clk) begin
    s0_m_r   <= {mag_nxt, 8'd0};
    s0_neg_r <= ang_u[ANGLE_W-1];
    s0_cos_r <= (in_opcode == OPC_COSINE);
  end

  // ---- stages 1..4: restoring division by pi/2, two steps in stages 1..3,
  // one in stage 4; the quotient is below 128, so the search starts at pi/2 * 64
  assign st_a = div_step(s0_m_r,         HALF_PI_Q32 << 6);
  assign st_b = div_step(st_a[RED_W-1:0], HALF_PI_Q32 << 5);
  assign st_c = div_step(s1_rem_r,       HALF_PI_Q32 << 4);
  assign st_d = div_step(st_c[RED_W-1:0], HALF_PI_Q32 << 3);
  assign st_e = div_step(s2_rem_r,       HALF_PI_Q32 << 2);
  assign st_f = div_step(st_e[RED_W-1:0], HALF_PI_Q32 << 1);
  assign st_g = div_step(s3_rem_r,       HALF_PI_Q32);

  always_ff @(posedge clk) begin
    s1_rem_r <= st_b[RED_W-1:0];
    s1_neg_r <= s0_neg_r;
    s1_cos_r <= s0_cos_r;

    s2_rem_r <= st_d[RED_W-1:0];
    s2_neg_r <= s1_neg_r;
    s2_cos_r <= s1_cos_r;

    s3_rem_r <= st_f[RED_W-1:0];
    s3_q1_r  <= st_f[RED_W];
    s3_neg_r <= s2_neg_r;
    s3_cos_r <= s2_cos_r;

    s4_f0_r  <= st_g[FOLD_W-1:0];
    s4_q0_r  <= st_g[RED_W];
    s4_q1_r  <= s3_q1_r;
    s4_neg_r <= s3_neg_r;
    s4_cos_r <= s3_cos_r;
  end

  // ---- stage 5: quadrant and fold
  // a negative angle mirrors the quadrant; an exact multiple of pi/2 maps
  // back onto the axis, so a negative exact multiple of 2*pi lands on zero
  assign q_lo = {s4_q1_r, s4_q0_r};

  always_comb begin
    priority if (!s4_neg_r) begin
      quad = q_lo;
    end else if (s4_f0_r != '0) begin
      quad = ~q_lo;
    end else begin
      quad = 2'd0 - q_lo;
    end
  end

  assign negres_nxt = s4_cos_r ? (quad == 2'd1 || quad == 2'd2) : quad[1];

  // the folded angle is f0 or pi/2 - f0 depending on quotient parity; below
  // pi/4 it feeds its own polynomial, from pi/4 up the other one takes
  // pi/2 minus it, which is again f0 or pi/2 - f0
  assign lo_sel = s4_q0_r ? (s4_f0_r <= QUARTER_PI_Q32) : (s4_f0_r < QUARTER_PI_Q32);
  assign swap   = ~(s4_q0_r ^ lo_sel);
  assign f_hi   = HALF_PI_F - s4_f0_r;
  assign u_nxt  = lo_sel ? s4_f0_r[POLY_W+1:2] : f_hi[POLY_W+1:2];

  always_ff @(posedge clk) begin
    s5_u_r   <= u_nxt;
    s5_pc_r  <= s4_cos_r ^ swap;   // high: cosine polynomial
    s5_neg_r <= negres_nxt;
  end

  // ---- stage 6: u^2
  assign p_u2 = s5_u_r * s5_u_r;

  always_ff @(posedge clk) begin
    s6_u_r   <= s5_u_r;
    s6_u2_r  <= p_u2[2*POLY_W-1:POLY_W];
    s6_pc_r  <= s5_pc_r;
    s6_neg_r <= s5_neg_r;
  end

  // ---- stage 7: u^4 for cosine, u^3 for sine
  assign mul_b = s6_pc_r ? s6_u2_r : s6_u_r;
  assign p_a   = s6_u2_r * mul_b;

  always_ff @(posedge clk) begin
    s7_u_r   <= s6_u_r;
    s7_u2_r  <= s6_u2_r;
    s7_a_r   <= p_a[2*POLY_W-1:POLY_W];
    s7_pc_r  <= s6_pc_r;
    s7_neg_r <= s6_neg_r;
  end

  // ---- stage 8: u^6 or u^5, and u^4/24 or u^3/6 (both end in a divide by 3)
  assign p_b  = s7_u2_r * s7_a_r;
  assign da_x = s7_pc_r ? {2'd0, s7_a_r[POLY_W-1:3]} : s7_a_r[POLY_W-1:1];
  assign p_da = da_x * RECIP3;

  always_ff @(posedge clk) begin
    s8_u_r   <= s7_u_r;
    s8_u2_r  <= s7_u2_r;
    s8_b_r   <= p_b[2*POLY_W-1:POLY_W];
    s8_da_r  <= p_da[57:30];
    s8_pc_r  <= s7_pc_r;
    s8_neg_r <= s7_neg_r;
  end

  // ---- stage 9: u^6/720 = (u^6/16)/45, u^5/120 = (u^5/8)/15
  assign db_x   = s8_pc_r ? {1'b0, s8_b_r[POLY_W-1:4]} : s8_b_r[POLY_W-1:3];
  assign db_m   = s8_pc_r ? RECIP45 : RECIP15;
  assign p_db   = db_x * db_m;
  assign db_nxt = s8_pc_r ? {2'd0, p_db[56:35]} : p_db[56:33];

  always_ff @(posedge clk) begin
    s9_u_r   <= s8_u_r;
    s9_u2_r  <= s8_u2_r;
    s9_da_r  <= s8_da_r;
    s9_db_r  <= db_nxt;
    s9_pc_r  <= s8_pc_r;
    s9_neg_r <= s8_neg_r;
  end

  // ---- stage 10: polynomial sum
  always_comb begin
    if (s9_pc_r) begin
      sum_nxt = ONE_Q30 - {3'd0, s9_u2_r[POLY_W-1:1]} + {4'd0, s9_da_r}
                - {8'd0, s9_db_r};
    end else begin
      sum_nxt = {2'd0, s9_u_r} - {4'd0, s9_da_r} + {8'd0, s9_db_r};
    end
  end

  always_ff @(posedge clk) begin
    s10_sum_r <= sum_nxt;
    s10_neg_r <= s9_neg_r;
  end

  // ---- stage 11: clamp to one, apply the quadrant sign
  assign sat           = (s10_sum_r > ONE_Q30) ? ONE_Q30 : s10_sum_r;
  assign out_value_nxt = s10_neg_r ? (~sat + 32'd1) : sat;

  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
  end

  assign out_valid = vld_r[LATENCY-1];
  assign out_value = out_value_r;

endmodule

### rtl/scp_checker.sv
// ----------------------------------------------------------------------------
// scp_checker: port-level checks for the sine/cosine polynomial block
// fixed latency, no stray results, output range and cosine of zero among the axis values
// ----------------------------------------------------------------------------
module scp_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input logic signed [scp_pkg::ANGLE_W-1:0] in_angle,
  input logic                               in_opcode,
  input logic                               out_valid,
  input logic signed [scp_pkg::VALUE_W-1:0] out_value
);
  import scp_pkg::*;

  logic signed [VALUE_W-1:0] one_s;
  logic signed [VALUE_W-1:0] minus_one_s;

  assign one_s       = ONE_Q30;
  assign minus_one_s = -one_s;

  // every transaction comes back after the pipeline depth
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("result strobe missing after accepted transaction");

  // no result without a transaction behind it
  a_no_stray : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result strobe without a matching transaction");

  // results stay within plus or minus one
  a_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_value <= one_s && out_value >= minus_one_s))
    else $error("result outside plus or minus one");

  // cosine of zero is exactly one
  a_cos_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_angle == '0 && in_opcode == OPC_COSINE)
      |-> ##LATENCY (out_value == one_s))
    else $error("cosine of zero is not one");

endmodule

bind sine_cosine_polynomial scp_checker u_scp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_angle  (in_angle),
  .in_opcode (in_opcode),
  .out_valid (out_valid),
  .out_value (out_value)
);
